[rtl/dweb_pkg.sv]
// Shared types and constants of the readout word event builder.
// Depends on nothing; the front end, queue, event logic, top level and testbench use it.
package dweb_pkg;

    // Field widths
    localparam int WORD_W     = 32;
    localparam int TS_W       = 48;
    localparam int CHAN_W     = 12;
    localparam int VALUE_W    = 16;
    localparam int HITS_W     = 8;
    localparam int WIN_W      = 20;
    localparam int CARD_W     = 7;
    localparam int UPPER_LSB  = 28;
    localparam int UPPER_W    = TS_W - UPPER_LSB;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = WIN_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_CARD  = 2'd2;

    // Register reset values
    localparam logic [WIN_W-1:0]  HIT_WINDOW_RST = 20'd65;
    localparam logic [HITS_W-1:0] MAX_HITS_RST   = 8'd6;
    localparam logic [CARD_W-1:0] SKIP_CARD_RST  = 7'd99;

    // Word classification
    localparam logic [WORD_W-1:0] FILL_PATTERN = 32'h5e5e_5e5e;
    localparam logic [WORD_W-1:0] FILL_ONES    = 32'hffff_ffff;
    localparam logic [WORD_W-1:0] DATA_MASK    = 32'hc000_0000;
    localparam logic [WORD_W-1:0] SYNC_MASK    = 32'hc0f0_0000;
    localparam logic [WORD_W-1:0] SYNC_CODE    = 32'h8040_0000;
    localparam logic [WORD_W-1:0] ROLL_LIMIT   = 32'h0000_001a;

    // Timestamp rollover period and hit counter ceiling
    localparam logic [TS_W-1:0]   ROLL_STEP = 48'h0000_1000_0000;
    localparam logic [HITS_W-1:0] HITS_SAT  = 8'd255;

    // One readout word
    typedef struct packed {
        logic [WORD_W-1:0] word_high;
        logic [WORD_W-1:0] word_low;
    } t_in_item;

    // One result
    typedef struct packed {
        logic               event_close;
        logic               hit_valid;
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
        logic [TS_W-1:0]    timestamp;
        logic [HITS_W-1:0]  hit_index;
        logic               last;
    } t_out_item;

    // Data word after timestamp extension, as queued for the event logic
    typedef struct packed {
        logic [TS_W-1:0]    timestamp;
        logic               rolled;
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
    } t_hit_item;

    // Event logic settings
    typedef struct packed {
        logic [WIN_W-1:0]  hit_window;
        logic [HITS_W-1:0] max_hits;
    } t_evt_cfg;

    // Queue status
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

[rtl/dweb_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type is set where the channel is instantiated.
interface dweb_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/dweb_front.sv]
// Front end: filler removal, word classification, card filter and
// 48-bit timestamp extension. Depends on dweb_pkg and dweb_stream_if.
module dweb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dweb_stream_if.sink                 i_in,
    input  logic [dweb_pkg::CARD_W-1:0] i_skip_card,
    input  dweb_pkg::t_q_status         i_q_status,
    output logic                        o_push,
    output dweb_pkg::t_hit_item         o_item
);
    import dweb_pkg::*;

    logic [TS_W-1:0]   r_time;
    logic              r_rolled;
    logic [TS_W-1:0]   n_time;
    logic              n_rolled;

    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] high;
    logic              accept;
    logic              is_fill;
    logic              is_data;
    logic              is_sync;
    logic              skip;
    logic              do_roll;
    logic [TS_W-1:0]   t_merged;
    logic [TS_W-1:0]   t_ext;

    assign low  = i_in.payload.word_low;
    assign high = i_in.payload.word_high;

    // Take a request whenever the queue has room
    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && !i_q_status.full;

    // Classify
    assign is_fill = ((low == '0) && (high == '0)) ||
                     ((low == FILL_PATTERN) && ((high == FILL_PATTERN) || (high == FILL_ONES)));
    assign is_data = (high & DATA_MASK) == DATA_MASK;
    assign is_sync = (high & SYNC_MASK) == SYNC_CODE;
    // card is ident / 32, i.e. ident bits 11..5
    assign skip    = high[27:21] == i_skip_card;

    // Timestamp extension: keep upper bits, merge low half, one rollover per sync
    assign t_merged = {r_time[TS_W-1:UPPER_LSB], {UPPER_LSB{1'b0}}}
                    | {{(TS_W-WORD_W){1'b0}}, low};
    assign do_roll  = (low <= ROLL_LIMIT) && !r_rolled;
    assign t_ext    = do_roll
                    ? {t_merged[TS_W-1:UPPER_LSB] + UPPER_W'(1), t_merged[UPPER_LSB-1:0]}
                    : t_merged;

    assign o_push           = accept && !is_fill && is_data && !skip;
    assign o_item.timestamp = t_ext;
    assign o_item.rolled    = do_roll;
    assign o_item.channel   = high[27:16];
    assign o_item.value     = high[15:0];

    // Next timestamp state
    always_comb begin
        n_time   = r_time;
        n_rolled = r_rolled;
        if (accept && !is_fill) begin
            if (is_data) begin
                if (!skip) begin
                    n_time = t_ext;
                    if (do_roll) begin
                        n_rolled = 1'b1;
                    end
                end
            end else if (is_sync) begin
                n_time   = {high[UPPER_W-1:0], {UPPER_LSB{1'b0}}}
                         | {{(TS_W-WORD_W){1'b0}}, low};
                n_rolled = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time   <= '0;
            r_rolled <= 1'b0;
        end else begin
            r_time   <= n_time;
            r_rolled <= n_rolled;
        end
    end

endmodule

[rtl/dweb_queue.sv]
// Small register queue between front end and event logic.
// Depends on dweb_pkg for the status type; entry type is a parameter.
module dweb_queue #(
    parameter int  DEPTH  = 4,
    parameter type t_data = logic
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_data               i_data,
    input  logic                i_pop,
    output t_data               o_head,
    output dweb_pkg::t_q_status o_status
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_data            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = r_count == '0;
    assign o_status.full  = r_count == CNT_W'(DEPTH);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

[rtl/dweb_back.sv]
// Event logic: coincidence window, hit limit, event close, output register.
// Depends on dweb_pkg and dweb_stream_if.
module dweb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dweb_pkg::t_evt_cfg  i_cfg,
    input  dweb_pkg::t_q_status i_q_status,
    input  dweb_pkg::t_hit_item i_head,
    output logic                o_pop,
    dweb_stream_if.source       o_out
);
    import dweb_pkg::*;

    logic [TS_W-1:0]   r_start;
    logic [HITS_W-1:0] r_hits;
    logic              r_phase;
    logic              r_ovalid;
    t_out_item         r_out;
    logic [TS_W-1:0]   n_start;
    logic [HITS_W-1:0] n_hits;
    logic              n_phase;
    logic              n_ovalid;
    t_out_item         n_out;

    logic [TS_W-1:0]   delta;
    logic              neg;
    logic              upper_zero;
    logic              below;
    logic              past;
    logic              emit_hit;
    logic              emit_reopen;
    logic              advance;

    function automatic t_out_item make_hit(t_hit_item item, logic [HITS_W-1:0] idx,
                                           logic last);
        t_out_item res;
        res.event_close = 1'b0;
        res.hit_valid   = 1'b1;
        res.channel     = item.channel;
        res.value       = item.value;
        res.timestamp   = item.timestamp;
        res.hit_index   = idx;
        res.last        = last;
        return res;
    endfunction

    function automatic t_out_item make_close(logic last);
        t_out_item res;
        res             = '0;
        res.event_close = 1'b1;
        res.last        = last;
        return res;
    endfunction

    // Offset from event start; an empty event starts at the pre-rollover time
    always_comb begin
        if (r_hits == '0) begin
            delta = i_head.rolled ? ROLL_STEP : '0;
        end else begin
            delta = i_head.timestamp - r_start;
        end
    end

    assign neg         = delta[TS_W-1];
    assign upper_zero  = delta[TS_W-1:WIN_W] == '0;
    assign below       = neg || (upper_zero && (delta[WIN_W-1:0] < i_cfg.hit_window));
    assign past        = !neg && (!upper_zero || (delta[WIN_W-1:0] > i_cfg.hit_window));
    assign emit_hit    = below && (r_hits < i_cfg.max_hits);
    // After a close the same hit opens the next event at offset zero
    assign emit_reopen = past && (i_cfg.hit_window != '0) && (i_cfg.max_hits != '0);

    assign advance = !i_q_status.empty && (!r_ovalid || o_out.ready);

    // Event state and result selection
    always_comb begin
        n_start  = r_start;
        n_hits   = r_hits;
        n_phase  = r_phase;
        n_ovalid = r_ovalid && !o_out.ready;
        n_out    = r_out;
        o_pop    = 1'b0;
        if (advance) begin
            if (r_phase) begin
                // second result of a closing word
                n_out    = make_hit(i_head, '0, 1'b1);
                n_ovalid = 1'b1;
                n_phase  = 1'b0;
                o_pop    = 1'b1;
            end else begin
                if (past) begin
                    n_start = i_head.timestamp;
                    n_hits  = HITS_W'(1);
                end else begin
                    if (r_hits == '0) begin
                        n_start = i_head.timestamp;
                    end
                    if (r_hits != HITS_SAT) begin
                        n_hits = r_hits + HITS_W'(1);
                    end
                end
                if (emit_hit) begin
                    n_out    = make_hit(i_head, r_hits, 1'b1);
                    n_ovalid = 1'b1;
                    o_pop    = 1'b1;
                end else if (past) begin
                    n_out    = make_close(!emit_reopen);
                    n_ovalid = 1'b1;
                    if (emit_reopen) begin
                        n_phase = 1'b1;
                    end else begin
                        o_pop = 1'b1;
                    end
                end else begin
                    o_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_hits   <= '0;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_start  <= n_start;
            r_hits   <= n_hits;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.payload = r_out;

    a_phase_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> !i_q_status.empty)
        else $error("reopen pending without queued word");
    a_phase_hits_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_hits == HITS_W'(1))
        else $error("reopen pending but hit count not one");
    a_reopen_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase && advance |=> r_ovalid && r_out.hit_valid && (r_out.hit_index == '0))
        else $error("reopened event did not start with hit zero");
    a_close_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.event_close |-> !r_out.hit_valid && (r_out.timestamp == '0))
        else $error("close marker carries hit fields");

endmodule

[rtl/daq_word_stream_event_builder_unit.sv]
// Readout word stream event builder: top level with configuration registers.
// Depends on dweb_pkg, dweb_stream_if, dweb_front, dweb_queue and dweb_back.
//
// Usage:
//   i_in  : sink channel of 64-bit readout words (word_low, word_high).
//   o_out : source channel of results (event_close, hit_valid, channel,
//           value, timestamp, hit_index, last); last marks the final result
//           of a word.
//   i_cfg_we/i_cfg_idx/i_cfg_data write hit_window (0), max_hits (1) and
//   skip_card (2); write only while the block is idle.
// A word is written into the queue when accepted; the event logic then
// registers its first result in the output register, which drives o_out.
// Throughput: one word per cycle while the queue has room. A word that closes
// an event and opens the next one makes two results and holds the event logic
// for both; the QUEUE_DEPTH-entry queue absorbs this while the front accepts.
// Reset clears the timestamp, event state, queue and output valid flag and
// loads the registers with 65, 6 and 99. When the receiver stalls, the
// result waits in the output register, the queue fills, and i_in.ready
// falls once the queue is full.
module daq_word_stream_event_builder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dweb_stream_if.sink                     i_in,
    dweb_stream_if.source                   o_out,
    input  logic                            i_cfg_we,
    input  logic [dweb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dweb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dweb_pkg::*;

    logic [WIN_W-1:0]  r_hit_window;
    logic [HITS_W-1:0] r_max_hits;
    logic [CARD_W-1:0] r_skip_card;

    t_evt_cfg          evt_cfg;
    t_q_status         q_status;
    t_hit_item         push_item;
    t_hit_item         head_item;
    logic              push;
    logic              pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_window <= HIT_WINDOW_RST;
            r_max_hits   <= MAX_HITS_RST;
            r_skip_card  <= SKIP_CARD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HIT_WINDOW: r_hit_window <= i_cfg_data[WIN_W-1:0];
                CFG_MAX_HITS:   r_max_hits   <= i_cfg_data[HITS_W-1:0];
                CFG_SKIP_CARD:  r_skip_card  <= i_cfg_data[CARD_W-1:0];
                default: ;
            endcase
        end
    end

    assign evt_cfg.hit_window = r_hit_window;
    assign evt_cfg.max_hits   = r_max_hits;

    dweb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_skip_card (r_skip_card),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_item      (push_item)
    );

    dweb_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .t_data (t_hit_item)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_status (q_status)
    );

    dweb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (evt_cfg),
        .i_q_status (q_status),
        .i_head     (head_item),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

[sim/tb_daq_word_stream_event_builder_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench of daq_word_stream_event_builder_unit: a directed table, then
// random readout word streams over several register settings, checked against a predictor.
// Depends on dweb_pkg, dweb_stream_if and the RTL of the block.
module tb_daq_word_stream_event_builder_unit;
    import dweb_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int N_ROWS          = 23;
    localparam int N_PHASES        = 6;

    // Directed table row: one readout word, optionally with its results written out
    typedef struct packed {
        logic [WORD_W-1:0] low;
        logic [WORD_W-1:0] high;
        logic              typed;
        logic [1:0]        n_res;
        t_out_item         res_a;
        t_out_item         res_b;
    } t_stim_row;

    // Random phase: register values (window 0 means draw all three at random)
    typedef struct packed {
        logic [WIN_W-1:0]  window;
        logic [HITS_W-1:0] max_hits;
        logic [CARD_W-1:0] skip;
        logic [7:0]        rare_pct;
        logic              idle;
        logic              write_cfg;
    } t_phase;

    localparam t_out_item NONE       = '0;
    localparam t_out_item CLOSE_ONLY = '{1'b1, 1'b0, 12'd0, 16'd0, 48'd0, 8'd0, 1'b0};

    // Rows run with the reset settings: window 65, max hits 6, skip card 99
    localparam t_stim_row STIM_ROWS [N_ROWS] = '{
        // fillers
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 2'd0, NONE, NONE},
        '{32'h5e5e_5e5e, 32'h5e5e_5e5e, 1'b1, 2'd0, NONE, NONE},
        '{32'h5e5e_5e5e, 32'hffff_ffff, 1'b1, 2'd0, NONE, NONE},
        // neither data nor sync
        '{32'h1234_5678, 32'h4000_0000, 1'b1, 2'd0, NONE, NONE},
        // sync, then first hit after reset with rollover: empty event closed first
        '{32'h0000_0100, 32'h8040_0001, 1'b1, 2'd0, NONE, NONE},
        '{32'h0000_0010, 32'hc123_beef, 1'b1, 2'd2, CLOSE_ONLY,
          '{1'b0, 1'b1, 12'h123, 16'hbeef, 48'h0000_2000_0010, 8'd0, 1'b1}},
        // skipped card
        '{32'h0000_0040, 32'hcc60_0001, 1'b1, 2'd0, NONE, NONE},
        // just inside, exactly at, and just past the window
        '{32'h0000_0050, 32'hc001_0002, 1'b0, 2'd0, NONE, NONE},
        '{32'h0000_0051, 32'hc002_0003, 1'b1, 2'd0, NONE, NONE},
        '{32'h0000_0052, 32'hc003_0004, 1'b0, 2'd0, NONE, NONE},
        // new sync period, rollover word closes the event
        '{32'h0000_0060, 32'h8040_0002, 1'b1, 2'd0, NONE, NONE},
        '{32'h0000_0005, 32'hc004_0005, 1'b0, 2'd0, NONE, NONE},
        // negative offset, field extremes, up to the hit limit
        '{32'h0000_0003, 32'hcfff_ffff, 1'b0, 2'd0, NONE, NONE},
        '{32'h0000_0006, 32'hc000_0000, 1'b0, 2'd0, NONE, NONE},
        '{32'h0000_0007, 32'hc7ff_8000, 1'b0, 2'd0, NONE, NONE},
        '{32'h0000_0008, 32'hc800_7fff, 1'b0, 2'd0, NONE, NONE},
        '{32'h0000_0009, 32'hc555_aaaa, 1'b0, 2'd0, NONE, NONE},
        '{32'h0000_000a, 32'hcaaa_5555, 1'b1, 2'd0, NONE, NONE},
        // all-ones timestamp, rollover wraps through 2^48
        '{32'hffff_ffff, 32'hbf4f_ffff, 1'b1, 2'd0, NONE, NONE},
        '{32'h0000_001a, 32'hdabc_1234, 1'b0, 2'd0, NONE, NONE},
        '{32'hffff_ffff, 32'hffff_fffe, 1'b0, 2'd0, NONE, NONE},
        // zero sync, zero low half data word
        '{32'h0000_0000, 32'h8040_0000, 1'b1, 2'd0, NONE, NONE},
        '{32'h0000_0000, 32'hc000_0000, 1'b0, 2'd0, NONE, NONE}
    };

    localparam t_phase PHASES [N_PHASES] = '{
        '{20'd65,      8'd6,   7'd99,  8'd4, 1'b1, 1'b0},
        '{20'd1,       8'd1,   7'd0,   8'd4, 1'b1, 1'b1},
        '{20'd1048575, 8'd255, 7'd127, 8'd0, 1'b1, 1'b1},
        '{20'd0,       8'd0,   7'd0,   8'd5, 1'b1, 1'b1},
        '{20'd300,     8'd4,   7'd40,  8'd3, 1'b1, 1'b1},
        '{20'd65,      8'd6,   7'd99,  8'd4, 1'b0, 1'b1}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    dweb_stream_if #(.t_payload(t_in_item))  in_ch ();
    dweb_stream_if #(.t_payload(t_out_item)) out_ch ();

    daq_word_stream_event_builder_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predictor state and its copy of the registers
    logic [TS_W-1:0]   ts_now       = '0;
    logic [TS_W-1:0]   evt_start    = '0;
    logic [HITS_W-1:0] hits_seen    = '0;
    logic              roll_done    = 1'b0;
    logic [WIN_W-1:0]  cfg_window   = HIT_WINDOW_RST;
    logic [HITS_W-1:0] cfg_max_hits = MAX_HITS_RST;
    logic [CARD_W-1:0] cfg_skip     = SKIP_CARD_RST;

    t_out_item   word_results[$];
    t_out_item   awaited_results[$];
    logic [31:0] data_low_run = '0;
    bit          idle_on      = 1'b1;
    int          rx_stall     = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Timestamp merge and window test for one data word; 1 when past the window
    function automatic bit place_data_word(input logic [31:0] lo, input logic [31:0] hi);
        logic [TS_W-1:0] t;
        logic [TS_W-1:0] d;
        bit              neg;
        t_out_item       r;
        t = {ts_now[TS_W-1:UPPER_LSB], 28'd0} | {16'd0, lo};
        if (hits_seen == 0) evt_start = t;
        if (lo <= ROLL_LIMIT && !roll_done) begin
            t = t + ROLL_STEP;
            roll_done = 1'b1;
        end
        ts_now = t;
        d = t - evt_start;
        neg = d[TS_W-1];
        if ((neg || d < {28'd0, cfg_window}) && hits_seen < cfg_max_hits) begin
            r = '0;
            r.hit_valid = 1'b1;
            r.channel   = hi[27:16];
            r.value     = hi[15:0];
            r.timestamp = t;
            r.hit_index = hits_seen;
            word_results = {word_results, r};
        end
        if (hits_seen == 0) evt_start = t;
        if (hits_seen != HITS_SAT) hits_seen = hits_seen + 1'b1;
        return !neg && d > {28'd0, cfg_window};
    endfunction

    // Results of one readout word, left in word_results
    function automatic void predict_word_results(input t_in_item w);
        t_out_item close_mark;
        t_out_item tail;
        word_results.delete();
        if (w.word_low == '0 && w.word_high == '0) return;
        if (w.word_low == FILL_PATTERN &&
            (w.word_high == FILL_PATTERN || w.word_high == FILL_ONES)) return;
        if ((w.word_high & DATA_MASK) == DATA_MASK) begin
            // card is ident / 32
            if (w.word_high[27:21] == cfg_skip) return;
            if (place_data_word(w.word_low, w.word_high)) begin
                close_mark = '0;
                close_mark.event_close = 1'b1;
                word_results = {word_results, close_mark};
                hits_seen = '0;
                void'(place_data_word(w.word_low, w.word_high));
            end
        end else if ((w.word_high & SYNC_MASK) == SYNC_CODE) begin
            ts_now = {w.word_high[19:0], 28'd0} | {16'd0, w.word_low};
            roll_done = 1'b0;
        end
        if (word_results.size() > 0) begin
            tail = word_results.pop_back();
            tail.last = 1'b1;
            word_results = {word_results, tail};
        end
    endfunction

    // Random readout word; mostly data words stepping through the window
    function automatic t_in_item make_word(input int rare_pct, output bit counts);
        t_in_item    w;
        int          pick;
        int unsigned step;
        logic [31:0] hi_rnd;
        pick   = $urandom_range(0, 99);
        hi_rnd = $urandom;
        counts = 1'b1;
        if (pick < rare_pct) begin
            // sync
            w.word_high = (hi_rnd & ~SYNC_MASK) | SYNC_CODE;
            w.word_low  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 255);
            data_low_run = w.word_low;
        end else if (pick < 2 * rare_pct) begin
            // rollover data word
            w.word_high = hi_rnd | DATA_MASK;
            w.word_low  = $urandom_range(0, ROLL_LIMIT);
            data_low_run = w.word_low;
        end else if (pick < 3 * rare_pct) begin
            // noise
            w.word_high = hi_rnd;
            w.word_low  = $urandom;
        end else if (pick < 3 * rare_pct + 3) begin
            counts = 1'b0;
            case ($urandom_range(0, 2))
                0:       w = '0;
                1:       w = {FILL_PATTERN, FILL_PATTERN};
                default: w = {FILL_ONES, FILL_PATTERN};
            endcase
        end else if (pick < 3 * rare_pct + 6) begin
            // word of the skipped card
            counts = 1'b0;
            w.word_high = {2'b11, hi_rnd[29:28], cfg_skip, hi_rnd[20:0]};
            w.word_low  = $urandom;
        end else begin
            if ($urandom_range(0, 99) < rare_pct)
                step = $urandom_range(0, 3 * cfg_window + 3);
            else if (cfg_window > 4096)
                step = $urandom_range(0, 64);
            else
                step = $urandom_range(0, cfg_window / 2 + 1);
            data_low_run = data_low_run + step;
            w.word_high  = hi_rnd | DATA_MASK;
            w.word_low   = data_low_run;
        end
        return w;
    endfunction

    // Hold the request until the block takes it
    task automatic send_word(input t_in_item w);
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic take_gap();
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Send one word and queue its expected results (typed ones when given)
    task automatic issue_word(input t_in_item w, input logic typed, input logic [1:0] n_res,
                              input t_out_item res_a, input t_out_item res_b);
        send_word(w);
        predict_word_results(w);
        if (typed) begin
            if (n_res > 0) awaited_results = {awaited_results, res_a};
            if (n_res > 1) awaited_results = {awaited_results, res_b};
        end else begin
            foreach (word_results[j]) awaited_results = {awaited_results, word_results[j]};
        end
    endtask

    // Drain, let words without results leave the pipe, then write all registers
    task automatic load_settings(input logic [WIN_W-1:0] win, input logic [HITS_W-1:0] mh,
                                 input logic [CARD_W-1:0] sk);
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_HIT_WINDOW;
        cfg_data <= win;
        @(posedge i_clk);
        cfg_idx  <= CFG_MAX_HITS;
        cfg_data <= CFG_DATA_W'(mh);
        @(posedge i_clk);
        cfg_idx  <= CFG_SKIP_CARD;
        cfg_data <= CFG_DATA_W'(sk);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cfg_window   = win;
        cfg_max_hits = mh;
        cfg_skip     = sk;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Result checker and receiver stall bursts
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, got %p",
                         $time, out_ch.payload);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("event_close", want.event_close, out_ch.payload.event_close);
                check_field("hit_valid", want.hit_valid, out_ch.payload.hit_valid);
                check_field("channel", want.channel, out_ch.payload.channel);
                check_field("value", want.value, out_ch.payload.value);
                check_field("timestamp", want.timestamp, out_ch.payload.timestamp);
                check_field("hit_index", want.hit_index, out_ch.payload.hit_index);
                check_field("last", want.last, out_ch.payload.last);
            end
        end
        if (rx_stall > 0)
            rx_stall--;
        else if (idle_on && $urandom_range(0, 7) == 0)
            rx_stall = $urandom_range(1, 16);
        out_ch.ready <= (rx_stall == 0);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_stim_row         row;
        t_phase            ph;
        t_in_item          w;
        bit                counts;
        int                n_done;
        int                k;
        int                p;
        logic [WIN_W-1:0]  win;
        logic [HITS_W-1:0] mh;
        logic [CARD_W-1:0] sk;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_HIT_WINDOW;
        cfg_data      <= '0;
        i_rst_n       <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table with the reset settings
        for (k = 0; k < N_ROWS; k++) begin
            row = STIM_ROWS[k];
            take_gap();
            issue_word({row.high, row.low}, row.typed, row.n_res, row.res_a, row.res_b);
        end

        // random phases
        for (p = 0; p < N_PHASES; p++) begin
            ph = PHASES[p];
            if (ph.write_cfg) begin
                win = ph.window;
                mh  = ph.max_hits;
                sk  = ph.skip;
                if (win == 0) begin
                    win = $urandom_range(1, 4095);
                    mh  = $urandom_range(1, 255);
                    sk  = $urandom_range(0, 127);
                end
                load_settings(win, mh, sk);
            end
            idle_on = ph.idle;
            n_done  = 0;
            while (n_done < ITEMS_PER_PHASE) begin
                w = make_word(ph.rare_pct, counts);
                take_gap();
                issue_word(w, 1'b0, 2'd0, NONE, NONE);
                if (counts) n_done++;
            end
        end

        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
